/* rtl/aps_pkg.sv */
// Shared types, constants and helpers for the adaptive position smoother.
// Used by every module of the block; depends on nothing else.
`default_nettype none
package aps_pkg;

  localparam int HISTORY_DEPTH_DEF   = 5;
  localparam int STILL_MIN_COUNT_DEF = 4;

  localparam int POS_W     = 32;
  localparam int GAIN_W    = 16;
  localparam int DT_IN_W   = 16;
  localparam int DT_W      = 12;
  localparam int CFG_IDX_W = 3;
  localparam int MAG_W     = 33;
  localparam int MB_W      = 22;
  localparam int NUM_W     = 56;
  localparam int DEN_W     = 50;
  localparam int SUM_W     = 44;
  localparam int WIDE_W    = 35;

  localparam logic [DT_W-1:0]   DT_MAX      = 12'd3277;
  localparam logic [MB_W-1:0]   ABS_FLOOR   = 22'd102;
  localparam logic [GAIN_W-1:0] UNITY_GAIN  = 16'd256;
  localparam logic [MAG_W-1:0]  SNAP_AXIS   = 33'd2048000;
  localparam logic [MAG_W-1:0]  STILL_AXIS  = 33'd10240;
  localparam logic [SUM_W-1:0]  SNAP_SQ     = SUM_W'(64'd4000000 << 20);
  localparam logic [SUM_W-1:0]  STILL_SQ    = SUM_W'(64'd100 << 20);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SMOOTH_H,
    CFG_DAMP_H,
    CFG_STOP_H,
    CFG_SMOOTH_V,
    CFG_DAMP_V,
    CFG_STOP_V,
    CFG_BYPASS_H,
    CFG_BYPASS_V
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SEED,
    ST_DIFF,
    ST_SQ,
    ST_SQACC,
    ST_SNAP,
    ST_DEN,
    ST_DEN2,
    ST_DEN3,
    ST_NUM1,
    ST_NUM2,
    ST_DIVGO,
    ST_DIVW,
    ST_MULW,
    ST_UPD,
    ST_OFFS,
    ST_EDIF,
    ST_ESQ,
    ST_ESQACC,
    ST_RESNAP,
    ST_FIN,
    ST_OUT
  } state_t;

  function automatic logic [POS_W-1:0] sat32(input logic [WIDE_W-1:0] v);
    logic [WIDE_W-POS_W:0] top;
    top = v[WIDE_W-1:POS_W-1];
    if (&top || ~|top) begin
      return v[POS_W-1:0];
    end else if (v[WIDE_W-1]) begin
      return {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      return {1'b0, {(POS_W-1){1'b1}}};
    end
  endfunction

endpackage
`default_nettype wire

/* rtl/adaptive_position_smoother.sv */
// Adaptive position smoother top level: sequencer, configuration and state.
// Depends on aps_pkg, aps_mul, aps_div and aps_hist.
//
// One word is worked at a time: the shared shift-and-add multiplier (one bit
// per cycle) forms the squared distances, the gain product and each axis
// numerator, and the 56-step restoring divider forms each axis step, so a
// fully smoothed frame costs roughly three divisions plus a dozen serial
// multiplies. Snapped and bypassed frames finish much sooner. A finished word
// waits in the output register while the next one is accepted.
`default_nettype none
module adaptive_position_smoother #(
  parameter int HISTORY_DEPTH   = aps_pkg::HISTORY_DEPTH_DEF,
  parameter int STILL_MIN_COUNT = aps_pkg::STILL_MIN_COUNT_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [aps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [aps_pkg::GAIN_W-1:0]     cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic signed [aps_pkg::POS_W-1:0] in_pos_x,
  input  wire logic signed [aps_pkg::POS_W-1:0] in_pos_y,
  input  wire logic signed [aps_pkg::POS_W-1:0] in_pos_z,
  input  wire logic [aps_pkg::DT_IN_W-1:0]    in_elapsed,
  input  wire logic                           in_airborne,
  input  wire logic                           in_indoors,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [aps_pkg::POS_W-1:0]    out_offset_x,
  output logic signed [aps_pkg::POS_W-1:0]    out_offset_y,
  output logic signed [aps_pkg::POS_W-1:0]    out_offset_z,
  output logic                                out_standing_still
);
  import aps_pkg::*;

  logic [GAIN_W-1:0] smooth_h_r, damp_h_r, stop_h_r;
  logic [GAIN_W-1:0] smooth_v_r, damp_v_r, stop_v_r;
  logic              byp_h_r, byp_v_r;

  logic [POS_W-1:0]  p_r [3];
  logic [POS_W-1:0]  s_r [3];
  logic [POS_W-1:0]  o_r [3];
  logic [MAG_W-1:0]  mag_r [3];
  logic              neg_r [3];
  logic [DT_W-1:0]   dt_r;
  logic              air_r, indoor_r, seed_r, still_r, grp_r;
  logic [POS_W-1:0]  app_x_r, app_y_r;
  logic [SUM_W-1:0]  sum_r;
  logic [1:0]        ax_r;
  logic [DEN_W-1:0]  den_r;

  state_t state_r, state_nxt, ret_r, ret_nxt;

  logic              out_valid_r, still_out_r;
  logic [POS_W-1:0]  out_x_r, out_y_r, out_z_r;

  logic              mul_start, mul_busy, div_start, div_busy;
  logic [NUM_W-1:0]  mul_a, mul_prod, div_quo;
  logic [MB_W-1:0]   mul_b;
  logic              hist_push, hist_still;

  logic [MAG_W-1:0]  cur_mag;
  logic [MB_W-1:0]   floor_a;
  logic [SUM_W-1:0]  sum_add;
  logic              big_any, e_big, g_byp;
  logic [GAIN_W-1:0] g_s, g_d, g_m;
  logic [MAG_W-1:0]  qc;
  logic [WIDE_W-1:0] upd_sum;
  logic [MAG_W-1:0]  dps [3];
  logic [MAG_W-1:0]  de [2];

  function automatic logic [MAG_W-1:0] mag_of(input logic [MAG_W-1:0] d);
    return d[MAG_W-1] ? (~d + 1'b1) : d;
  endfunction

  aps_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a_in  (mul_a),
    .b_in  (mul_b),
    .busy  (mul_busy),
    .prod  (mul_prod)
  );

  aps_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num_in (mul_prod),
    .den_in (den_r),
    .busy   (div_busy),
    .quo    (div_quo)
  );

  aps_hist #(
    .DEPTH     (HISTORY_DEPTH),
    .MIN_COUNT (STILL_MIN_COUNT)
  ) u_hist (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (hist_push),
    .key   ({p_r[0], p_r[1]}),
    .still (hist_still)
  );

  assign hist_push = (state_r == ST_SEED);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dps[i] = {p_r[i][POS_W-1], p_r[i]} - {s_r[i][POS_W-1], s_r[i]};
    end
    de[0] = {o_r[0][POS_W-1], o_r[0]} - {app_x_r[POS_W-1], app_x_r};
    de[1] = {o_r[1][POS_W-1], o_r[1]} - {app_y_r[POS_W-1], app_y_r};
  end

  assign cur_mag = mag_r[ax_r];
  assign floor_a = (cur_mag < MAG_W'(ABS_FLOOR)) ? ABS_FLOOR : cur_mag[MB_W-1:0];
  assign sum_add = sum_r + mul_prod[SUM_W-1:0];
  assign big_any = (mag_r[0] > SNAP_AXIS) || (mag_r[1] > SNAP_AXIS) ||
                   (mag_r[2] > SNAP_AXIS);
  assign e_big   = (mag_r[0] > STILL_AXIS) || (mag_r[1] > STILL_AXIS);

  assign g_s   = grp_r ? smooth_v_r : smooth_h_r;
  assign g_d   = grp_r ? damp_v_r : damp_h_r;
  assign g_m   = still_r ? (grp_r ? stop_v_r : stop_h_r) : UNITY_GAIN;
  assign g_byp = ((grp_r ? byp_v_r : byp_h_r) && indoor_r) || (g_s == '0) ||
                 (g_d == '0) || (g_m == '0);

  assign qc      = (|div_quo[NUM_W-1:MAG_W]) ? '1 : div_quo[MAG_W-1:0];
  assign upd_sum = {{(WIDE_W-POS_W){s_r[ax_r][POS_W-1]}}, s_r[ax_r]} +
                   (neg_r[ax_r] ? (~{2'b00, qc} + 1'b1) : {2'b00, qc});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ret_r   <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    in_ready  = 1'b0;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = ST_SEED;
        end
      end
      ST_SEED: state_nxt = ST_DIFF;
      ST_DIFF: state_nxt = ST_SQ;
      ST_SQ: begin
        if (air_r || big_any) begin
          state_nxt = ST_SNAP;
        end else begin
          mul_start = 1'b1;
          mul_a     = NUM_W'(cur_mag);
          mul_b     = cur_mag[MB_W-1:0];
          ret_nxt   = ST_SQACC;
          state_nxt = ST_MULW;
        end
      end
      ST_MULW: begin
        if (!mul_busy) begin
          state_nxt = ret_r;
        end
      end
      ST_SQACC: begin
        if (ax_r == 2'd2) begin
          state_nxt = (sum_add > SNAP_SQ) ? ST_SNAP : ST_DEN;
        end else begin
          state_nxt = ST_SQ;
        end
      end
      ST_SNAP: state_nxt = ST_OFFS;
      ST_DEN: begin
        if (g_byp) begin
          state_nxt = grp_r ? ST_OFFS : ST_DEN;
        end else begin
          mul_start = 1'b1;
          mul_a     = NUM_W'(g_s);
          mul_b     = MB_W'(g_d);
          ret_nxt   = ST_DEN2;
          state_nxt = ST_MULW;
        end
      end
      ST_DEN2: begin
        mul_start = 1'b1;
        mul_a     = mul_prod;
        mul_b     = MB_W'(g_m);
        ret_nxt   = ST_DEN3;
        state_nxt = ST_MULW;
      end
      ST_DEN3: state_nxt = ST_NUM1;
      ST_NUM1: begin
        mul_start = 1'b1;
        mul_a     = NUM_W'(cur_mag);
        mul_b     = floor_a;
        ret_nxt   = ST_NUM2;
        state_nxt = ST_MULW;
      end
      ST_NUM2: begin
        mul_start = 1'b1;
        mul_a     = mul_prod;
        mul_b     = MB_W'(dt_r);
        ret_nxt   = ST_DIVGO;
        state_nxt = ST_MULW;
      end
      ST_DIVGO: begin
        div_start = 1'b1;
        state_nxt = ST_DIVW;
      end
      ST_DIVW: begin
        if (!div_busy) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        if (ax_r == 2'd0) begin
          state_nxt = ST_NUM1;
        end else if (ax_r == 2'd1) begin
          state_nxt = ST_DEN;
        end else begin
          state_nxt = ST_OFFS;
        end
      end
      ST_OFFS: state_nxt = ST_EDIF;
      ST_EDIF: state_nxt = still_r ? ST_ESQ : ST_FIN;
      ST_ESQ: begin
        if (e_big) begin
          state_nxt = ST_RESNAP;
        end else begin
          mul_start = 1'b1;
          mul_a     = NUM_W'(cur_mag);
          mul_b     = cur_mag[MB_W-1:0];
          ret_nxt   = ST_ESQACC;
          state_nxt = ST_MULW;
        end
      end
      ST_ESQACC: begin
        if (ax_r == 2'd1) begin
          state_nxt = (sum_add > STILL_SQ) ? ST_RESNAP : ST_FIN;
        end else begin
          state_nxt = ST_ESQ;
        end
      end
      ST_RESNAP: state_nxt = ST_OUT;
      ST_FIN:    state_nxt = ST_OUT;
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smooth_h_r  <= '0;
      damp_h_r    <= '0;
      stop_h_r    <= UNITY_GAIN;
      smooth_v_r  <= '0;
      damp_v_r    <= '0;
      stop_v_r    <= UNITY_GAIN;
      byp_h_r     <= 1'b0;
      byp_v_r     <= 1'b0;
      s_r[0]      <= '0;
      s_r[1]      <= '0;
      s_r[2]      <= '0;
      seed_r      <= 1'b1;
      app_x_r     <= '0;
      app_y_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_SMOOTH_H: smooth_h_r <= cfg_data;
          CFG_DAMP_H:   damp_h_r   <= cfg_data;
          CFG_STOP_H:   stop_h_r   <= cfg_data;
          CFG_SMOOTH_V: smooth_v_r <= cfg_data;
          CFG_DAMP_V:   damp_v_r   <= cfg_data;
          CFG_STOP_V:   stop_v_r   <= cfg_data;
          CFG_BYPASS_H: byp_h_r    <= cfg_data[0];
          CFG_BYPASS_V: byp_v_r    <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid_r && out_ready && state_r != ST_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            p_r[0]   <= in_pos_x;
            p_r[1]   <= in_pos_y;
            p_r[2]   <= in_pos_z;
            dt_r     <= (in_elapsed > DT_IN_W'(DT_MAX)) ? DT_MAX : in_elapsed[DT_W-1:0];
            air_r    <= in_airborne;
            indoor_r <= in_indoors;
          end
        end
        ST_SEED: begin
          if (seed_r && p_r[2] != '0) begin
            s_r[0] <= p_r[0];
            s_r[1] <= p_r[1];
            s_r[2] <= p_r[2];
            seed_r <= 1'b0;
          end
          still_r <= hist_still;
        end
        ST_DIFF: begin
          for (int i = 0; i < 3; i++) begin
            mag_r[i] <= mag_of(dps[i]);
            neg_r[i] <= dps[i][MAG_W-1];
          end
          sum_r <= '0;
          ax_r  <= 2'd0;
          grp_r <= 1'b0;
        end
        ST_SQACC: begin
          sum_r <= sum_add;
          ax_r  <= ax_r + 2'd1;
        end
        ST_SNAP: begin
          s_r[0] <= p_r[0];
          s_r[1] <= p_r[1];
          s_r[2] <= p_r[2];
        end
        ST_DEN: begin
          if (g_byp) begin
            if (grp_r) begin
              s_r[2] <= p_r[2];
            end else begin
              s_r[0] <= p_r[0];
              s_r[1] <= p_r[1];
              grp_r  <= 1'b1;
            end
          end
        end
        ST_DEN3: begin
          den_r <= {mul_prod[DEN_W-3:0], 2'b00};
          ax_r  <= grp_r ? 2'd2 : 2'd0;
        end
        ST_UPD: begin
          s_r[ax_r] <= sat32(upd_sum);
          if (ax_r == 2'd0) begin
            ax_r <= 2'd1;
          end else if (ax_r == 2'd1) begin
            grp_r <= 1'b1;
          end
        end
        ST_OFFS: begin
          for (int i = 0; i < 3; i++) begin
            o_r[i] <= sat32({{(WIDE_W-POS_W){s_r[i][POS_W-1]}}, s_r[i]} -
                            {{(WIDE_W-POS_W){p_r[i][POS_W-1]}}, p_r[i]});
          end
        end
        ST_EDIF: begin
          mag_r[0] <= mag_of(de[0]);
          mag_r[1] <= mag_of(de[1]);
          sum_r    <= '0;
          ax_r     <= 2'd0;
        end
        ST_ESQACC: begin
          sum_r <= sum_add;
          ax_r  <= 2'd1;
        end
        ST_RESNAP: begin
          s_r[0] <= p_r[0];
          s_r[1] <= p_r[1];
          o_r[0] <= app_x_r;
          o_r[1] <= app_y_r;
          o_r[2] <= '0;
        end
        ST_FIN: begin
          app_x_r <= o_r[0];
          app_y_r <= o_r[1];
        end
        ST_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_x_r     <= o_r[0];
            out_y_r     <= o_r[1];
            out_z_r     <= o_r[2];
            still_out_r <= still_r;
            out_valid_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_offset_x       = out_x_r;
  assign out_offset_y       = out_y_r;
  assign out_offset_z       = out_z_r;
  assign out_standing_still = still_out_r;

  a_mul_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mul_start |-> !mul_busy)
    else $error("multiplier restarted while busy");

  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIVGO) |-> (den_r != '0))
    else $error("division started with a zero divisor");

  a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && (!out_valid_r || out_ready)) |=> out_valid_r)
    else $error("finished word not presented");

endmodule
`default_nettype wire

/* rtl/aps_mul.sv */
// Shift-and-add multiplier that retires one multiplier bit per cycle.
// Depends on aps_pkg for operand widths.
`default_nettype none
module aps_mul (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [aps_pkg::NUM_W-1:0] a_in,
  input  wire logic [aps_pkg::MB_W-1:0]  b_in,
  output logic                          busy,
  output logic [aps_pkg::NUM_W-1:0]      prod
);
  import aps_pkg::*;

  logic [NUM_W-1:0] acc_r;
  logic [NUM_W-1:0] a_r;
  logic [MB_W-1:0]  b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r <= '0;
    end else if (start) begin
      b_r <= b_in;
    end else if (b_r != '0) begin
      b_r <= b_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      a_r   <= a_in;
    end else if (b_r != '0) begin
      if (b_r[0]) begin
        acc_r <= acc_r + a_r;
      end
      a_r <= a_r << 1;
    end
  end

  assign busy = (b_r != '0);
  assign prod = acc_r;

endmodule
`default_nettype wire

/* rtl/aps_div.sv */
// Restoring divider that produces one quotient bit per cycle.
// Depends on aps_pkg for numerator and divisor widths.
`default_nettype none
module aps_div (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [aps_pkg::NUM_W-1:0] num_in,
  input  wire logic [aps_pkg::DEN_W-1:0] den_in,
  output logic                          busy,
  output logic [aps_pkg::NUM_W-1:0]      quo
);
  import aps_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign shifted = {rem_r, quo_r[NUM_W-1]};
  assign ge      = (shifted >= {1'b0, den_r});
  assign diff    = shifted - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNT_W'(NUM_W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      den_r <= den_in;
      quo_r <= num_in;
    end else if (cnt_r != '0) begin
      rem_r <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], ge};
    end
  end

  assign busy = (cnt_r != '0);
  assign quo  = quo_r;

endmodule
`default_nettype wire

/* rtl/aps_hist.sv */
// History of recent xy positions and the stillness test over them.
// Depends on aps_pkg for the position width.
`default_nettype none
module aps_hist #(
  parameter int DEPTH     = aps_pkg::HISTORY_DEPTH_DEF,
  parameter int MIN_COUNT = aps_pkg::STILL_MIN_COUNT_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  wire logic [2*aps_pkg::POS_W-1:0] key,
  output logic                            still
);
  import aps_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [2*POS_W-1:0] ent_r [DEPTH];
  logic [CW-1:0]      cnt_r;
  logic               full;
  logic               match;

  assign full = (cnt_r == CW'(DEPTH));

  always_comb begin
    match = 1'b1;
    for (int i = 1; i < DEPTH; i++) begin
      if (i < int'(cnt_r) && ent_r[i] != ent_r[0]) begin
        match = 1'b0;
      end
    end
    still = (int'(cnt_r) >= MIN_COUNT) && match;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (push && !full) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_ent
    logic [2*POS_W-1:0] shift_in;
    if (g == DEPTH - 1) begin : g_last
      assign shift_in = key;
    end else begin : g_mid
      assign shift_in = ent_r[g+1];
    end
    always_ff @(posedge clk) begin
      if (push) begin
        if (full) begin
          ent_r[g] <= shift_in;
        end else if (CW'(g) == cnt_r) begin
          ent_r[g] <= key;
        end
      end
    end
  end

endmodule
`default_nettype wire
